>>> rtl/trnr_pkg.sv
// Shared types, codes and defaults for the table-routed router.
package trnr_pkg;

   // Default sizes
   localparam int DEF_MAX_PORTS  = 8;
   localparam int DEF_FIFO_DEPTH = 8;
   localparam int DEF_MAX_NODES  = 64;

   // Request codes
   localparam logic [2:0] REQ_ARRIVE  = 3'd0;
   localparam logic [2:0] REQ_TICK    = 3'd1;
   localparam logic [2:0] REQ_STALL   = 3'd2;
   localparam logic [2:0] REQ_UNSTALL = 3'd3;
   localparam logic [2:0] REQ_ROUTE   = 3'd4;

   // Result kinds
   localparam logic [1:0] KIND_STATUS  = 2'd0;
   localparam logic [1:0] KIND_FORWARD = 2'd1;
   localparam logic [1:0] KIND_DROP    = 2'd2;

   // Register indexes
   localparam logic [2:0] CSR_OWN_NODE     = 3'd0;
   localparam logic [2:0] CSR_LOCAL_PORT   = 3'd1;
   localparam logic [2:0] CSR_QUEUE_LIMIT  = 3'd2;
   localparam logic [2:0] CSR_ROUTE_COUNT  = 3'd3;
   localparam logic [2:0] CSR_ACTIVE_PORTS = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_ROUTE,
      ST_DECIDE,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic accept;
      logic fifo_rd;
      logic route_rd;
      logic commit;
      logic advance;
      logic move_pend;
      logic move_last;
   } cmd_type;

   typedef struct packed {
      logic is_arrival;
      logic is_tick;
      logic head_empty;
      logic go;
      logic out_free;
      logic pend_valid;
      logic last_port;
   } status_type;

endpackage

>>> rtl/trnr_ctrl.sv
// Sequencer for requests and the round-robin tick scan.
module trnr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  trnr_pkg::status_type status,
   output trnr_pkg::cmd_type    cmd
);

   trnr_pkg::state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= trnr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         trnr_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (status.is_arrival) begin
                  state_in = trnr_pkg::ST_FLUSH;
               end else if (status.is_tick) begin
                  state_in = trnr_pkg::ST_FETCH;
               end
            end
         end
         trnr_pkg::ST_FETCH: begin
            if (status.head_empty) begin
               cmd.advance = 1'b1;
               if (status.last_port) begin
                  state_in = status.pend_valid ? trnr_pkg::ST_FLUSH : trnr_pkg::ST_IDLE;
               end
            end else begin
               cmd.fifo_rd = 1'b1;
               state_in    = trnr_pkg::ST_ROUTE;
            end
         end
         trnr_pkg::ST_ROUTE: begin
            cmd.route_rd = 1'b1;
            state_in     = trnr_pkg::ST_DECIDE;
         end
         trnr_pkg::ST_DECIDE: begin
            // hold while a finished result cannot move out
            if (!(status.go && status.pend_valid && !status.out_free)) begin
               cmd.commit    = 1'b1;
               cmd.advance   = 1'b1;
               cmd.move_pend = status.go && status.pend_valid;
               if (status.last_port) begin
                  state_in = (status.pend_valid || status.go) ?
                             trnr_pkg::ST_FLUSH : trnr_pkg::ST_IDLE;
               end else begin
                  state_in = trnr_pkg::ST_FETCH;
               end
            end
         end
         trnr_pkg::ST_FLUSH: begin
            if (status.out_free) begin
               cmd.move_pend = 1'b1;
               cmd.move_last = 1'b1;
               state_in      = trnr_pkg::ST_IDLE;
            end
         end
         default: state_in = trnr_pkg::ST_IDLE;
      endcase
   end

endmodule

>>> rtl/trnr_datapath.sv
// FIFOs, route table, registers and result path of the router.
module trnr_datapath #(
   parameter int MAX_PORTS  = trnr_pkg::DEF_MAX_PORTS,
   parameter int FIFO_DEPTH = trnr_pkg::DEF_FIFO_DEPTH,
   parameter int MAX_NODES  = trnr_pkg::DEF_MAX_NODES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [2:0]           req_type,
   input  logic [2:0]           req_port,
   input  logic [5:0]           req_dest,
   input  logic [31:0]          req_payload,
   input  logic                 csr_we,
   input  logic [2:0]           csr_index,
   input  logic [6:0]           csr_wdata,
   input  trnr_pkg::cmd_type    cmd,
   output trnr_pkg::status_type status,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_kind,
   output logic [2:0]           rsp_in_port,
   output logic [2:0]           rsp_out_port,
   output logic [5:0]           rsp_dest_out,
   output logic [31:0]          rsp_payload_out,
   output logic                 rsp_input_full,
   output logic                 rsp_release_upstream,
   output logic                 rsp_last
);

   localparam int PW   = $clog2(MAX_PORTS);
   localparam int NPW  = $clog2(MAX_PORTS + 1);
   localparam int PCW  = (NPW > 4) ? NPW : 4;
   localparam int FW   = $clog2(FIFO_DEPTH);
   localparam int CNW  = $clog2(FIFO_DEPTH + 1);
   localparam int LW   = (CNW > 3) ? CNW : 3;
   localparam int MD   = MAX_PORTS * FIFO_DEPTH;
   localparam int MW   = $clog2(MD);
   localparam int NW   = $clog2(MAX_NODES);
   localparam int DW   = (NW > 6) ? NW : 6;
   localparam int NCW  = $clog2(MAX_NODES + 1);
   localparam int CMPW = (NCW > 7) ? NCW : 7;

   // Configuration registers
   logic [5:0] own_node_ff;
   logic [2:0] local_port_ff;
   logic [2:0] queue_limit_ff;
   logic [6:0] route_count_ff;
   logic [3:0] active_ports_ff;

   // Router state
   logic [37:0]    fifo_mem [MD];
   logic [2:0]     route_mem [MAX_NODES];
   logic [FW-1:0]  head_ff [MAX_PORTS];
   logic [CNW-1:0] count_ff [MAX_PORTS];
   logic [7:0]     stall_ff;
   logic [7:0]     used_ff;
   logic [PW-1:0]  rr_ff;
   logic [PW-1:0]  idx_ff;
   logic [PCW-1:0] scan_ff;
   logic [37:0]    fifo_q_ff;
   logic [2:0]     route_q_ff;

   // Pending result and output register
   logic        pend_valid_ff;
   logic [1:0]  pend_kind_ff;
   logic [2:0]  pend_in_ff, pend_out_ff;
   logic [5:0]  pend_dest_ff;
   logic [31:0] pend_pl_ff;
   logic        pend_full_ff, pend_rel_ff;
   logic        rsp_valid_ff;
   logic [1:0]  rsp_kind_ff;
   logic [2:0]  rsp_in_ff, rsp_out_ff;
   logic [5:0]  rsp_dest_ff;
   logic [31:0] rsp_pl_ff;
   logic        rsp_full_ff, rsp_rel_ff, rsp_last_ff;

   logic [PCW-1:0] ap_ext, n_eff, port_ext, nx_ext;
   logic [LW-1:0]  lim;
   logic [CMPW-1:0] rc_eff;
   logic [PW-1:0]  port_idx, sel, nx_idx, rr_start;
   logic [FW-1:0]  head_sel, slot, head_nx;
   logic [CNW-1:0] cnt_sel, cnt_inc, cnt_dec;
   logic [FW:0]    slot_sum, head_sum;
   logic [MW-1:0]  wr_addr, rd_addr;
   logic           port_ok, fifo_full, arr_full, arr_push;
   logic [5:0]     ent_dest;
   logic [31:0]    ent_pl;
   logic [DW-1:0]  ent_dext, req_dext;
   logic [2:0]     op;
   logic           err, go, rel, route_we;

   // Effective limits
   always_comb begin
      ap_ext = PCW'(active_ports_ff);
      if (ap_ext == '0) begin
         n_eff = PCW'(1);
      end else if (ap_ext > PCW'(MAX_PORTS)) begin
         n_eff = PCW'(MAX_PORTS);
      end else begin
         n_eff = ap_ext;
      end
      lim = (LW'(queue_limit_ff) < LW'(FIFO_DEPTH - 1)) ? LW'(queue_limit_ff)
                                                      : LW'(FIFO_DEPTH - 1);
      rc_eff = (CMPW'(route_count_ff) < CMPW'(MAX_NODES)) ? CMPW'(route_count_ff)
                                                         : CMPW'(MAX_NODES);
   end

   // Port selection: request port on accept, scan index otherwise
   assign port_ext = PCW'(req_port);
   assign port_idx = port_ext[PW-1:0];
   assign sel      = cmd.accept ? port_idx : idx_ff;
   assign head_sel = head_ff[sel];
   assign cnt_sel  = count_ff[sel];
   assign cnt_inc  = cnt_sel + CNW'(1);
   assign cnt_dec  = cnt_sel - CNW'(1);

   // Arrival push
   always_comb begin
      port_ok   = port_ext < n_eff;
      fifo_full = cnt_sel == CNW'(FIFO_DEPTH);
      slot_sum  = (FW + 1)'(head_sel) + (FW + 1)'(cnt_sel);
      if (slot_sum >= (FW + 1)'(FIFO_DEPTH)) begin
         slot_sum = slot_sum - (FW + 1)'(FIFO_DEPTH);
      end
      slot     = slot_sum[FW-1:0];
      wr_addr  = MW'(port_idx) * MW'(FIFO_DEPTH) + MW'(slot);
      arr_full = port_ok && (fifo_full || (LW'(cnt_inc) > lim));
      arr_push = cmd.accept && (req_type == trnr_pkg::REQ_ARRIVE) && port_ok && !fifo_full;
   end

   // Head decision
   always_comb begin
      rd_addr  = MW'(idx_ff) * MW'(FIFO_DEPTH) + MW'(head_sel);
      ent_dest = fifo_q_ff[37:32];
      ent_pl   = fifo_q_ff[31:0];
      ent_dext = DW'(ent_dest);
      req_dext = DW'(req_dest);
      op       = (ent_dest == own_node_ff) ? local_port_ff : route_q_ff;
      err      = (CMPW'(ent_dest) >= rc_eff) || (PCW'(op) >= n_eff);
      go       = err || (!used_ff[op] && !stall_ff[op]);
      rel      = LW'(cnt_dec) == lim;
      head_sum = (FW + 1)'(head_sel) + (FW + 1)'(1);
      head_nx  = (head_sum == (FW + 1)'(FIFO_DEPTH)) ? '0 : head_sum[FW-1:0];
      nx_ext   = PCW'(idx_ff) + PCW'(1);
      nx_idx   = (nx_ext == n_eff) ? '0 : nx_ext[PW-1:0];
      rr_start = (PCW'(rr_ff) < n_eff) ? rr_ff : '0;
      route_we = cmd.accept && (req_type == trnr_pkg::REQ_ROUTE) &&
                 (CMPW'(req_dest) < CMPW'(MAX_NODES));
   end

   // Memories
   always_ff @(posedge clock) begin
      if (arr_push) begin
         fifo_mem[wr_addr] <= {req_dest, req_payload};
      end
      if (cmd.fifo_rd) begin
         fifo_q_ff <= fifo_mem[rd_addr];
      end
      if (route_we) begin
         route_mem[req_dext[NW-1:0]] <= req_port;
      end
      if (cmd.route_rd) begin
         route_q_ff <= route_mem[ent_dext[NW-1:0]];
      end
   end

   // Configuration, queue control and scan state
   always_ff @(posedge clock) begin
      if (reset) begin
         own_node_ff     <= '0;
         local_port_ff   <= '0;
         queue_limit_ff  <= 3'd4;
         route_count_ff  <= 7'd64;
         active_ports_ff <= 4'd5;
         stall_ff        <= '0;
         used_ff         <= '0;
         rr_ff           <= '0;
         idx_ff          <= '0;
         scan_ff         <= '0;
         for (int i = 0; i < MAX_PORTS; i++) begin
            head_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               trnr_pkg::CSR_OWN_NODE:     own_node_ff     <= csr_wdata[5:0];
               trnr_pkg::CSR_LOCAL_PORT:   local_port_ff   <= csr_wdata[2:0];
               trnr_pkg::CSR_QUEUE_LIMIT:  queue_limit_ff  <= csr_wdata[2:0];
               trnr_pkg::CSR_ROUTE_COUNT:  route_count_ff  <= csr_wdata;
               trnr_pkg::CSR_ACTIVE_PORTS: active_ports_ff <= csr_wdata[3:0];
               default: ;
            endcase
         end
         if (arr_push) begin
            count_ff[sel] <= cnt_inc;
         end
         if (cmd.accept && req_type == trnr_pkg::REQ_STALL) begin
            stall_ff[req_port] <= 1'b1;
         end
         if (cmd.accept && req_type == trnr_pkg::REQ_UNSTALL) begin
            stall_ff[req_port] <= 1'b0;
         end
         // start a tick scan
         if (cmd.accept && req_type == trnr_pkg::REQ_TICK) begin
            idx_ff  <= rr_start;
            scan_ff <= '0;
            used_ff <= '0;
         end
         // claim the output of a valid route, and pop on a forward or drop
         if (cmd.commit) begin
            if (!err) begin
               used_ff[op] <= 1'b1;
            end
            if (go) begin
               head_ff[sel]  <= head_nx;
               count_ff[sel] <= cnt_dec;
               rr_ff         <= nx_idx;
            end
         end
         if (cmd.advance) begin
            idx_ff  <= nx_idx;
            scan_ff <= scan_ff + PCW'(1);
         end
      end
   end

   // Pending result slot
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else if (cmd.accept && req_type == trnr_pkg::REQ_ARRIVE) begin
         pend_valid_ff <= 1'b1;
      end else if (cmd.commit && go) begin
         pend_valid_ff <= 1'b1;
      end else if (cmd.move_pend) begin
         pend_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && req_type == trnr_pkg::REQ_ARRIVE) begin
         pend_kind_ff <= trnr_pkg::KIND_STATUS;
         pend_in_ff   <= req_port;
         pend_out_ff  <= '0;
         pend_dest_ff <= req_dest;
         pend_pl_ff   <= req_payload;
         pend_full_ff <= arr_full;
         pend_rel_ff  <= 1'b0;
      end else if (cmd.commit && go) begin
         pend_kind_ff <= err ? trnr_pkg::KIND_DROP : trnr_pkg::KIND_FORWARD;
         pend_in_ff   <= 3'(idx_ff);
         pend_out_ff  <= err ? 3'd0 : op;
         pend_dest_ff <= ent_dest;
         pend_pl_ff   <= ent_pl;
         pend_full_ff <= 1'b0;
         pend_rel_ff  <= rel;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.move_pend) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.move_pend) begin
         rsp_kind_ff <= pend_kind_ff;
         rsp_in_ff   <= pend_in_ff;
         rsp_out_ff  <= pend_out_ff;
         rsp_dest_ff <= pend_dest_ff;
         rsp_pl_ff   <= pend_pl_ff;
         rsp_full_ff <= pend_full_ff;
         rsp_rel_ff  <= pend_rel_ff;
         rsp_last_ff <= cmd.move_last;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_kind             = rsp_kind_ff;
   assign rsp_in_port          = rsp_in_ff;
   assign rsp_out_port         = rsp_out_ff;
   assign rsp_dest_out         = rsp_dest_ff;
   assign rsp_payload_out      = rsp_pl_ff;
   assign rsp_input_full       = rsp_full_ff;
   assign rsp_release_upstream = rsp_rel_ff;
   assign rsp_last             = rsp_last_ff;

   // Status to the controller
   always_comb begin
      status.is_arrival = req_type == trnr_pkg::REQ_ARRIVE;
      status.is_tick    = req_type == trnr_pkg::REQ_TICK;
      status.head_empty = cnt_sel == '0;
      status.go         = go;
      status.out_free   = !rsp_valid_ff || rsp_ready;
      status.pend_valid = pend_valid_ff;
      status.last_port  = (scan_ff + PCW'(1)) == n_eff;
   end

endmodule

>>> rtl/table_routed_noc_router_top.sv
// Arrival: the transfer in idle, then a flush state that loads the status into the output register.
// Tick: the transfer, then a scan visiting one port per step: an empty port is skipped in the
// fetch state, a non-empty port goes through FIFO read, route table read and decision, and a
// flush state hands over a final pending result; output stalls can hold decision and flush.
// Other requests are taken in idle. Synchronous active-high reset clears queues, stall flags
// and the round-robin pointer and restores register defaults; FIFO and table contents stay.
module table_routed_noc_router_top #(
   parameter int MAX_PORTS  = trnr_pkg::DEF_MAX_PORTS,
   parameter int FIFO_DEPTH = trnr_pkg::DEF_FIFO_DEPTH,
   parameter int MAX_NODES  = trnr_pkg::DEF_MAX_NODES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_type,
   input  logic [2:0]  req_port,
   input  logic [5:0]  req_dest,
   input  logic [31:0] req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [2:0]  rsp_in_port,
   output logic [2:0]  rsp_out_port,
   output logic [5:0]  rsp_dest_out,
   output logic [31:0] rsp_payload_out,
   output logic        rsp_input_full,
   output logic        rsp_release_upstream,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [6:0]  csr_wdata
);

   trnr_pkg::cmd_type    cmd;
   trnr_pkg::status_type status;

   trnr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   trnr_datapath #(
      .MAX_PORTS  (MAX_PORTS),
      .FIFO_DEPTH (FIFO_DEPTH),
      .MAX_NODES  (MAX_NODES)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .req_type             (req_type),
      .req_port             (req_port),
      .req_dest             (req_dest),
      .req_payload          (req_payload),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .cmd                  (cmd),
      .status               (status),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_kind             (rsp_kind),
      .rsp_in_port          (rsp_in_port),
      .rsp_out_port         (rsp_out_port),
      .rsp_dest_out         (rsp_dest_out),
      .rsp_payload_out      (rsp_payload_out),
      .rsp_input_full       (rsp_input_full),
      .rsp_release_upstream (rsp_release_upstream),
      .rsp_last             (rsp_last)
   );

endmodule

>>> rtl/trnr_checker.sv
// Port-level checks for the router, bound to the top level.
module trnr_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [2:0] req_type,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_kind,
   input logic [2:0] rsp_out_port,
   input logic       rsp_release_upstream
);

   // A stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // An arrival transfer keeps the block busy until its status is handed over
   a_arrive_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_type == trnr_pkg::REQ_ARRIVE |=> !req_ready)
      else $error("ready high right after arrival");

   // Stall, unstall and route writes leave the block ready again in the next cycle
   a_ctl_quick: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_type == trnr_pkg::REQ_STALL ||
         req_type == trnr_pkg::REQ_UNSTALL || req_type == trnr_pkg::REQ_ROUTE)
      |=> req_ready)
      else $error("control request did not return to idle");

   // Arrival status carries no output port and no release
   a_status_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == trnr_pkg::KIND_STATUS |->
         !rsp_release_upstream && rsp_out_port == 3'd0)
      else $error("arrival status carries routing fields");

   // Only defined kinds appear
   a_kind_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_kind != 2'd3)
      else $error("undefined result kind");

endmodule

bind table_routed_noc_router_top trnr_checker u_trnr_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_ready            (req_ready),
   .req_type             (req_type),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_kind             (rsp_kind),
   .rsp_out_port         (rsp_out_port),
   .rsp_release_upstream (rsp_release_upstream)
);

>>> tb/tb.sv
// Self-checking testbench for the table-routed router: stimulus, prediction and result checks.
`timescale 1ns / 100ps

module tb;

   typedef struct {
      logic [2:0]  typ;
      logic [2:0]  port;
      logic [5:0]  dest;
      logic [31:0] payload;
   } req_item_type;

   typedef struct {
      logic [1:0]  kind;
      logic [2:0]  in_port;
      logic [2:0]  out_port;
      logic [5:0]  dest;
      logic [31:0] payload;
      logic        full;
      logic        rel;
      logic        last;
   } router_rsp_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_type;
   logic [2:0]  req_port;
   logic [5:0]  req_dest;
   logic [31:0] req_payload;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_kind;
   logic [2:0]  rsp_in_port;
   logic [2:0]  rsp_out_port;
   logic [5:0]  rsp_dest_out;
   logic [31:0] rsp_payload_out;
   logic        rsp_input_full;
   logic        rsp_release_upstream;
   logic        rsp_last;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [6:0]  csr_wdata;

   table_routed_noc_router_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
      .req_port(req_port), .req_dest(req_dest), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_kind(rsp_kind),
      .rsp_in_port(rsp_in_port), .rsp_out_port(rsp_out_port),
      .rsp_dest_out(rsp_dest_out), .rsp_payload_out(rsp_payload_out),
      .rsp_input_full(rsp_input_full), .rsp_release_upstream(rsp_release_upstream),
      .rsp_last(rsp_last),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Router state as seen by the predictor
   logic [37:0] q_store [8][8];
   logic [2:0]  q_head  [8];
   logic [3:0]  q_count [8];
   logic [7:0]  out_stalled;
   logic [2:0]  rr_ptr;
   logic [2:0]  route_tab [64];

   // Register copies
   logic [5:0] r_own_node;
   logic [2:0] r_local_port;
   logic [2:0] r_queue_limit;
   logic [6:0] r_route_count;
   logic [3:0] r_active_ports;

   req_item_type   pending_q [$];
   router_rsp_type expected_q [$];
   int          in_flight = 0;
   bit          hold = 0;
   bit          no_idle = 0;
   int          send_gap = 0;
   int          ready_gap = 0;
   bit          req_fire;
   bit          rsp_fire;
   int          mismatches = 0;
   int          items_sent = 0;
   int          rsp_seen = 0;
   int          fwd_seen = 0;
   int          drop_seen = 0;
   int          full_seen = 0;
   int          cycles = 0;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Idle length: mostly zero or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (no_idle || r < 60) return 0;
      if (r < 93) return $urandom_range(3, 1);
      return $urandom_range(30, 8);
   endfunction

   function automatic int eff_ports();
      if (r_active_ports < 1) return 1;
      if (r_active_ports > 8) return 8;
      return r_active_ports;
   endfunction

   // Work out the results of one accepted request and queue them
   task automatic predict_router(input req_item_type it);
      int          n, lim, rc, idx, start;
      logic [7:0]  claimed;
      logic [37:0] e;
      logic [5:0]  d;
      logic [2:0]  op;
      bit          err, go;
      router_rsp_type r;
      n = eff_ports();
      lim = (r_queue_limit < 7) ? r_queue_limit : 7;
      start = expected_q.size();
      r = '{default: '0};
      case (it.typ)
         trnr_pkg::REQ_ARRIVE: begin
            r.kind = trnr_pkg::KIND_STATUS;
            r.in_port = it.port;
            r.dest = it.dest;
            r.payload = it.payload;
            if (it.port < n) begin
               if (q_count[it.port] >= 8) begin
                  r.full = 1;
               end else begin
                  q_store[it.port][3'(q_head[it.port] + q_count[it.port])] =
                     {it.dest, it.payload};
                  q_count[it.port]++;
                  r.full = (q_count[it.port] > lim);
               end
            end
            expected_q.insert(expected_q.size(), r);
         end
         trnr_pkg::REQ_TICK: begin
            idx = (rr_ptr < n) ? rr_ptr : 0;
            claimed = '0;
            rc = (r_route_count < 64) ? r_route_count : 64;
            for (int i = 0; i < n; i++) begin
               if (q_count[idx] != 0) begin
                  e = q_store[idx][q_head[idx]];
                  d = e[37:32];
                  err = 0;
                  go = 1;
                  op = '0;
                  if (d >= rc) err = 1;
                  else if (d == r_own_node) op = r_local_port;
                  else op = route_tab[d];
                  if (!err && op >= n) err = 1;
                  if (!err) begin
                     if (claimed[op]) go = 0;
                     else begin
                        claimed[op] = 1;
                        if (out_stalled[op]) go = 0;
                     end
                  end
                  if (go) begin
                     q_head[idx]++;
                     q_count[idx]--;
                     r = '{default: '0};
                     r.kind = err ? trnr_pkg::KIND_DROP : trnr_pkg::KIND_FORWARD;
                     r.in_port = 3'(idx);
                     r.out_port = err ? 3'd0 : op;
                     r.dest = d;
                     r.payload = e[31:0];
                     r.rel = (q_count[idx] == lim);
                     expected_q.insert(expected_q.size(), r);
                     rr_ptr = (idx + 1 == n) ? 3'd0 : 3'(idx + 1);
                  end
               end
               idx = (idx + 1 == n) ? 0 : idx + 1;
            end
         end
         trnr_pkg::REQ_STALL:   out_stalled[it.port] = 1'b1;
         trnr_pkg::REQ_UNSTALL: out_stalled[it.port] = 1'b0;
         trnr_pkg::REQ_ROUTE:   route_tab[it.dest] = it.port;
         default: ;
      endcase
      if (expected_q.size() > start) expected_q[$].last = 1'b1;
   endtask

   // Driver: present pending requests, predict each transfer
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         req_fire = req_valid && req_ready;
         if (req_fire) begin
            predict_router('{req_type, req_port, req_dest, req_payload});
            items_sent++;
            in_flight--;
            send_gap = pick_gap();
         end
         if (!req_valid || req_fire) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_q.size() > 0 && !hold) begin
               req_item_type it;
               it = pending_q.pop_front();
               req_valid <= 1'b1;
               req_type <= it.typ;
               req_port <= it.port;
               req_dest <= it.dest;
               req_payload <= it.payload;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each result transfer with the oldest expectation
   always @(posedge clock) begin
      cycles++;
      if (cycles > 600000) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAIL");
         $finish;
      end
      rsp_fire = rsp_valid && rsp_ready && !reset;
      if (rsp_fire) begin
         rsp_seen++;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: kind %0d in %0d payload %h",
                        rsp_kind, rsp_in_port, rsp_payload_out);
         end else begin
            router_rsp_type x;
            x = expected_q.pop_front();
            if (x.kind == trnr_pkg::KIND_FORWARD) fwd_seen++;
            if (x.kind == trnr_pkg::KIND_DROP) drop_seen++;
            if (x.full) full_seen++;
            if (rsp_kind !== x.kind || rsp_in_port !== x.in_port ||
                rsp_out_port !== x.out_port || rsp_dest_out !== x.dest ||
                rsp_payload_out !== x.payload || rsp_input_full !== x.full ||
                rsp_release_upstream !== x.rel || rsp_last !== x.last) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("exp: kind %0d in %0d out %0d dest %0d pl %h full %0d rel %0d last %0d",
                           x.kind, x.in_port, x.out_port, x.dest, x.payload,
                           x.full, x.rel, x.last);
                  $display("got: kind %0d in %0d out %0d dest %0d pl %h full %0d rel %0d last %0d",
                           rsp_kind, rsp_in_port, rsp_out_port, rsp_dest_out,
                           rsp_payload_out, rsp_input_full, rsp_release_upstream,
                           rsp_last);
               end
            end
         end
      end
      // Drive ready with random stalls
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (ready_gap > 0) begin
         ready_gap--;
         rsp_ready <= 1'b0;
      end else begin
         ready_gap = pick_gap();
         rsp_ready <= (ready_gap == 0);
      end
   end

   task automatic push_item(input logic [2:0] t, input logic [2:0] p,
                            input logic [5:0] d, input logic [31:0] pl);
      pending_q.insert(pending_q.size(), '{t, p, d, pl});
      in_flight++;
   endtask

   // Wait until every request is in and every result is out, then let a scan finish
   task automatic wait_drained();
      do @(negedge clock); while (in_flight != 0 || expected_q.size() != 0);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [6:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         trnr_pkg::CSR_OWN_NODE:     r_own_node = val[5:0];
         trnr_pkg::CSR_LOCAL_PORT:   r_local_port = val[2:0];
         trnr_pkg::CSR_QUEUE_LIMIT:  r_queue_limit = val[2:0];
         trnr_pkg::CSR_ROUTE_COUNT:  r_route_count = val;
         trnr_pkg::CSR_ACTIVE_PORTS: r_active_ports = val[3:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_regs(input logic [5:0] own, input logic [2:0] lp,
                           input logic [2:0] ql, input logic [6:0] rc,
                           input logic [3:0] ap);
      write_reg(trnr_pkg::CSR_OWN_NODE, 7'(own));
      write_reg(trnr_pkg::CSR_LOCAL_PORT, 7'(lp));
      write_reg(trnr_pkg::CSR_QUEUE_LIMIT, 7'(ql));
      write_reg(trnr_pkg::CSR_ROUTE_COUNT, rc);
      write_reg(trnr_pkg::CSR_ACTIVE_PORTS, 7'(ap));
   endtask

   // Random traffic, weighted toward arrivals and ticks that route
   task automatic random_traffic(input int count);
      int r, n, rc;
      logic [5:0] d;
      n = eff_ports();
      rc = (r_route_count < 64) ? r_route_count : 64;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         if (r < 50) begin
            case ($urandom_range(9))
               0:       d = r_own_node;
               1, 2:    d = 6'($urandom);
               default: d = (rc > 0) ? 6'($urandom_range(rc - 1)) : 6'($urandom);
            endcase
            if ($urandom_range(9) == 0)
               push_item(trnr_pkg::REQ_ARRIVE, 3'($urandom), d, $urandom);
            else
               push_item(trnr_pkg::REQ_ARRIVE, 3'($urandom_range(n - 1)), d, $urandom);
         end else if (r < 86) begin
            push_item(trnr_pkg::REQ_TICK, 3'($urandom), 6'($urandom), $urandom);
         end else if (r < 91) begin
            push_item(trnr_pkg::REQ_STALL, 3'($urandom), 6'($urandom), $urandom);
         end else if (r < 96) begin
            push_item(trnr_pkg::REQ_UNSTALL, 3'($urandom), 6'($urandom), $urandom);
         end else if (r < 98) begin
            push_item(trnr_pkg::REQ_ROUTE, 3'($urandom), 6'($urandom), $urandom);
         end else begin
            push_item(3'($urandom_range(7, 5)), 3'($urandom), 6'($urandom), $urandom);
         end
      end
   endtask

   initial begin
      req_type = '0;
      req_port = '0;
      req_dest = '0;
      req_payload = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      out_stalled = '0;
      rr_ptr = '0;
      r_own_node = '0;
      r_local_port = '0;
      r_queue_limit = 3'd4;
      r_route_count = 7'd64;
      r_active_ports = 4'd5;
      foreach (q_head[i]) begin
         q_head[i] = '0;
         q_count[i] = '0;
      end
      reset = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Fill the whole route table so no entry is read before it is written
      for (int i = 0; i < 64; i++)
         push_item(trnr_pkg::REQ_ROUTE, (i < 2) ? 3'(i * 7) : 3'($urandom), 6'(i), $urandom);
      wait_drained();

      // Directed: overflow, drops, stalls, unused codes
      set_regs(6'd63, 3'd1, 3'd1, 7'd40, 4'd8);
      write_reg(3'd7, 7'h7f);
      for (int i = 0; i < 9; i++)
         push_item(trnr_pkg::REQ_ARRIVE, 3'd0, 6'd63, 32'(i));
      push_item(trnr_pkg::REQ_ARRIVE, 3'd7, 6'd63, 32'hffffffff);
      push_item(trnr_pkg::REQ_ARRIVE, 3'd3, 6'd45, 32'h0);
      push_item(trnr_pkg::REQ_ARRIVE, 3'd2, 6'd0, 32'h0);
      push_item(trnr_pkg::REQ_STALL, 3'd1, 6'd0, 32'h0);
      push_item(trnr_pkg::REQ_TICK, 3'd0, 6'd0, 32'h0);
      push_item(trnr_pkg::REQ_UNSTALL, 3'd1, 6'd0, 32'h0);
      push_item(3'd5, 3'd7, 6'd63, 32'hffffffff);
      push_item(3'd6, 3'd0, 6'd0, 32'h0);
      push_item(3'd7, 3'd5, 6'd21, 32'ha5a5a5a5);
      for (int i = 0; i < 7; i++)
         push_item(trnr_pkg::REQ_TICK, 3'd0, 6'd0, 32'h0);
      wait_drained();

      // Random phases across register settings, extremes included
      no_idle = 1;
      set_regs(6'd0, 3'd0, 3'd7, 7'd64, 4'd2);
      random_traffic(70);
      wait_drained();
      no_idle = 0;
      set_regs(6'd17, 3'd7, 3'd0, 7'd127, 4'd15);
      random_traffic(40);
      // Hold the sender until the router has emptied its results
      hold = 1;
      do @(negedge clock); while (expected_q.size() != 0);
      hold = 0;
      random_traffic(40);
      wait_drained();
      set_regs(6'd5, 3'd3, 3'd2, 7'd1, 4'd0);
      random_traffic(50);
      wait_drained();
      set_regs(6'd33, 3'd4, 3'd5, 7'd0, 4'd8);
      random_traffic(40);
      wait_drained();
      for (int ph = 0; ph < 3; ph++) begin
         set_regs(6'($urandom), 3'($urandom), 3'($urandom_range(7, 1)),
                  7'($urandom_range(64, 1)), 4'($urandom_range(8, 2)));
         random_traffic(45);
         wait_drained();
      end

      $display("sent %0d requests, checked %0d results", items_sent, rsp_seen);
      $display("%0d forwarded, %0d dropped, %0d full, %0d mismatches",
               fwd_seen, drop_seen, full_seen, mismatches);
      if (mismatches == 0 && expected_q.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/trnr_pkg.sv
rtl/trnr_ctrl.sv
rtl/trnr_datapath.sv
rtl/table_routed_noc_router_top.sv
rtl/trnr_checker.sv
tb/tb.sv
